@@ sv/assert_macros.svh @@
// Assertion helper macros for the texture sampler RTL.
// Used by the top level; expects signals clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tsp_pkg.sv @@
// Shared types and constants for the texture sampler.
// No dependencies; used by tsp_blend and texture_sampler_point_bilinear_core.
`timescale 1ns / 1ps

package tsp_pkg;

  // Fixed field widths
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 16;
  localparam int INDEX_W   = 16;
  localparam int WORD_W    = 32;
  localparam int CHAN_W    = 8;
  localparam int COORD_W   = 24;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Filter modes
  localparam logic FILTER_POINT    = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd2;

  localparam logic [CFG_W-1:0] SIDE_RESET = 9'd256;

  typedef struct packed {
    logic                      command;
    logic [INDEX_W-1:0]        texel_index;
    logic [WORD_W-1:0]         texel_word;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
  } request_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } result_t;

  // Travels with each texel read into the blend unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic alpha_hit;
  } blend_tag_t;

endpackage

@@ sv/tsp_blend.sv @@
// Weighted texel accumulation and rounding for the texture sampler.
// Depends on tsp_pkg; fed by the texel memory read port of the top level.
`timescale 1ns / 1ps

module tsp_blend #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tsp_pkg::blend_tag_t       tag,
  input  logic [2*WEIGHT_BITS:0]    wgt,
  input  logic [tsp_pkg::WORD_W-1:0] rdata,
  output logic                      result_valid,
  output tsp_pkg::result_t          result
);

  localparam int WGT_W  = 2 * WEIGHT_BITS + 1;
  localparam int PROD_W = tsp_pkg::CHAN_W + WGT_W;
  localparam int SHIFT  = 2 * WEIGHT_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SHIFT - 1);

  tsp_pkg::blend_tag_t              p_tag;
  logic [2:0][PROD_W-1:0]           prod;
  logic [2:0][PROD_W-1:0]           acc;
  logic [2:0][PROD_W-1:0]           sum;
  logic [2:0][tsp_pkg::CHAN_W-1:0]  chan;
  logic [tsp_pkg::CHAN_W-1:0]       alpha_hold;

  // Product stage: one texel channel times its combined weight
  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
    end else begin
      p_tag <= tag;
    end
    for (int c = 0; c < 3; c++) begin
      prod[c] <= PROD_W'(rdata[c*tsp_pkg::CHAN_W +: tsp_pkg::CHAN_W]) * PROD_W'(wgt);
    end
    if (tag.valid && tag.alpha_hit) begin
      alpha_hold <= rdata[3*tsp_pkg::CHAN_W +: tsp_pkg::CHAN_W];
    end
  end

  // Accumulate, round half up, saturate
  always_comb begin
    logic [PROD_W-1:0] rnd;
    for (int c = 0; c < 3; c++) begin
      sum[c] = (p_tag.first ? '0 : acc[c]) + prod[c];
      rnd    = sum[c] + HALF;
      if (rnd[SHIFT + tsp_pkg::CHAN_W]) begin
        chan[c] = '1;
      end else begin
        chan[c] = rnd[SHIFT +: tsp_pkg::CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p_tag.valid && p_tag.last;
    end
    if (p_tag.valid) begin
      acc <= sum;
    end
    if (p_tag.valid && p_tag.last) begin
      result.red   <= chan[0];
      result.green <= chan[1];
      result.blue  <= chan[2];
      result.alpha <= alpha_hold;
    end
  end

endmodule

@@ sv/texture_sampler_point_bilinear_core.sv @@
// Texture sampler top level: command pipeline, texel memory, read sequencer.
// Depends on tsp_pkg, tsp_blend and assert_macros.svh.
`timescale 1ns / 1ps

// A load writes one texel and produces no result; a sample produces one result,
// shown for a single cycle with result_valid high, which the receiver must take
// as it comes. Loads and point samples enter at one per cycle while busy is low;
// a bilinear sample holds the read sequencer for four texel reads from the
// single-port texel memory, so a bilinear sample that follows one cannot enter the
// sequencer until those reads are done, and busy stays high while the pipeline
// ahead of the sequencer is full.
// Commands act on the memory strictly in order, so a sample sees every earlier
// load. TEXEL_DEPTH must be a power of two: addresses wrap modulo the depth.
// A texel that was never loaded reads as unknown data.
module texture_sampler_point_bilinear_core #(
  parameter int MAX_SIDE    = 256,
  parameter int TEXEL_DEPTH = 65536,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tsp_pkg::request_t             request,
  input  logic                          cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsp_pkg::CFG_W-1:0]     cfg_data,
  output logic                          result_valid,
  output tsp_pkg::result_t              result
);

  `include "assert_macros.svh"

  localparam int FB      = tsp_pkg::FRAC_BITS;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int CRD_W   = $clog2(MAX_SIDE);
  localparam int ADDR_W  = $clog2(TEXEL_DEPTH);
  localparam int CMP_W   = (SIDE_W > tsp_pkg::CFG_W) ? SIDE_W : tsp_pkg::CFG_W;
  localparam int POS_W   = FB + SIDE_W;
  localparam int ROWP_W  = CRD_W + SIDE_W;
  localparam int SUM_W   = (ADDR_W > ROWP_W + 1) ? ADDR_W : ROWP_W + 1;
  localparam int LADDR_W = (ADDR_W > tsp_pkg::INDEX_W) ? ADDR_W : tsp_pkg::INDEX_W;
  localparam int WGT_W   = 2 * WEIGHT_BITS + 1;
  localparam logic [WEIGHT_BITS:0] ONE    = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
  localparam logic [WGT_W-1:0]     ONE_SQ = WGT_W'(1) << (2 * WEIGHT_BITS);

  // Clamp a size register to 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] eff_side(input logic [tsp_pkg::CFG_W-1:0] s);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(s);
    if (ext == '0) begin
      return SIDE_W'(1);
    end else if (ext > CMP_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end
    return SIDE_W'(ext);
  endfunction

  // Split a scaled position into point index, bilinear pair and weight
  function automatic void split_pos(
    input  logic [POS_W-1:0]       pos,
    input  logic [SIDE_W-1:0]      side,
    output logic [CRD_W-1:0]       p,
    output logic [CRD_W-1:0]       i0,
    output logic [CRD_W-1:0]       i1,
    output logic [WEIGHT_BITS-1:0] wt,
    output logic                   sel1
  );
    logic [SIDE_W-1:0] sm1;
    logic [SIDE_W-1:0] nxt;
    sm1 = side - SIDE_W'(1);
    p   = pos[FB +: CRD_W];
    // Below the texel center the left neighbor is one back, wrapping at zero
    if (pos[FB-1]) begin
      i0 = p;
    end else if (p == '0) begin
      i0 = sm1[CRD_W-1:0];
    end else begin
      i0 = p - CRD_W'(1);
    end
    nxt  = SIDE_W'(i0) + SIDE_W'(1);
    i1   = (nxt >= side) ? '0 : nxt[CRD_W-1:0];
    wt   = {~pos[FB-1], pos[FB-2 -: WEIGHT_BITS-1]};
    sel1 = ~pos[FB-1];
  endfunction

  // Configuration registers
  logic [tsp_pkg::CFG_W-1:0] tex_width;
  logic [tsp_pkg::CFG_W-1:0] tex_height;
  logic                      filter_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= tsp_pkg::SIDE_RESET;
      tex_height  <= tsp_pkg::SIDE_RESET;
      filter_mode <= tsp_pkg::FILTER_POINT;
    end else if (cfg_we) begin
      case (cfg_index)
        tsp_pkg::REG_TEX_WIDTH:   tex_width   <= cfg_data;
        tsp_pkg::REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        tsp_pkg::REG_FILTER_MODE: filter_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline registers
  logic                         s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic                         s1_load, s2_load, s3_load, s4_load, s5_load;
  logic                         s1_bil, s2_bil, s3_bil, s4_bil, s5_bil;
  logic [tsp_pkg::INDEX_W-1:0]  s1_index, s2_index, s3_index, s4_index, s5_index;
  logic [tsp_pkg::WORD_W-1:0]   s1_word, s2_word, s3_word, s4_word, s5_word;
  logic [SIDE_W-1:0]            s1_w, s1_h, s2_w, s2_h, s3_w;
  logic [FB-1:0]                s1_fu, s1_fv;
  logic [POS_W-1:0]             s2_pu, s2_pv;
  logic [CRD_W-1:0]             s3_pcol, s3_prow, s3_x0, s3_x1, s3_y0, s3_y1;
  logic [CRD_W-1:0]             s4_pcol, s4_x0, s4_x1, s5_pcol, s5_x0, s5_x1;
  logic [WEIGHT_BITS-1:0]       s3_a, s3_b, s4_a, s4_b, s5_a, s5_b;
  logic                         s3_selx, s3_sely, s4_selx, s4_sely, s5_selx, s5_sely;
  logic [ROWP_W-1:0]            s4_base0, s4_base1, s5_base0, s5_base1;
  logic [1:0]                   s5_phase;

  // Stall chain: a stage takes new work when empty or when it hands off
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s5_done, accept;

  always_comb begin
    s5_done  = s5_valid && (s5_load || !s5_bil || s5_phase == 2'd3);
    s5_ready = !s5_valid || s5_done;
    s4_ready = !s4_valid || s5_ready;
    s3_ready = !s3_valid || s4_ready;
    s2_ready = !s2_valid || s3_ready;
    s1_ready = !s1_valid || s2_ready;
  end

  assign busy   = !s1_ready;
  assign accept = start && !busy;

  // Stage 1: capture the request and the effective sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept;
    end
    if (s1_ready) begin
      s1_load  <= request.command == tsp_pkg::CMD_LOAD;
      s1_bil   <= filter_mode == tsp_pkg::FILTER_BILINEAR;
      s1_index <= request.texel_index;
      s1_word  <= request.texel_word;
      s1_fu    <= request.u_coord[FB-1:0];
      s1_fv    <= request.v_coord[FB-1:0];
      s1_w     <= eff_side(tex_width);
      s1_h     <= eff_side(tex_height);
    end
  end

  // Stage 2: scale the wrapped fractions by the texture size
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready) begin
      s2_load  <= s1_load;
      s2_bil   <= s1_bil;
      s2_index <= s1_index;
      s2_word  <= s1_word;
      s2_w     <= s1_w;
      s2_h     <= s1_h;
      s2_pu    <= POS_W'(s1_fu) * POS_W'(s1_w);
      s2_pv    <= POS_W'(s1_fv) * POS_W'(s1_h);
    end
  end

  // Stage 3: texel indices and weights
  logic [CRD_W-1:0]       pcol_c, prow_c, x0_c, x1_c, y0_c, y1_c;
  logic [WEIGHT_BITS-1:0] a_c, b_c;
  logic                   selx_c, sely_c;

  always_comb begin
    split_pos(s2_pu, s2_w, pcol_c, x0_c, x1_c, a_c, selx_c);
    split_pos(s2_pv, s2_h, prow_c, y0_c, y1_c, b_c, sely_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready) begin
      s3_load  <= s2_load;
      s3_bil   <= s2_bil;
      s3_index <= s2_index;
      s3_word  <= s2_word;
      s3_w     <= s2_w;
      s3_pcol  <= pcol_c;
      s3_prow  <= prow_c;
      s3_x0    <= x0_c;
      s3_x1    <= x1_c;
      s3_y0    <= y0_c;
      s3_y1    <= y1_c;
      s3_a     <= a_c;
      s3_b     <= b_c;
      s3_selx  <= selx_c;
      s3_sely  <= sely_c;
    end
  end

  // Stage 4: row base addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
    if (s4_ready) begin
      s4_load  <= s3_load;
      s4_bil   <= s3_bil;
      s4_index <= s3_index;
      s4_word  <= s3_word;
      s4_pcol  <= s3_pcol;
      s4_x0    <= s3_x0;
      s4_x1    <= s3_x1;
      s4_a     <= s3_a;
      s4_b     <= s3_b;
      s4_selx  <= s3_selx;
      s4_sely  <= s3_sely;
      s4_base0 <= ROWP_W'(s3_bil ? s3_y0 : s3_prow) * ROWP_W'(s3_w);
      s4_base1 <= ROWP_W'(s3_y1) * ROWP_W'(s3_w);
    end
  end

  // Stage 5: read sequencer, one memory access per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      s5_phase <= 2'd0;
    end else if (s5_ready) begin
      s5_valid <= s4_valid;
      s5_phase <= 2'd0;
    end else begin
      s5_phase <= s5_phase + 2'd1;
    end
    if (s5_ready) begin
      s5_load  <= s4_load;
      s5_bil   <= s4_bil;
      s5_index <= s4_index;
      s5_word  <= s4_word;
      s5_pcol  <= s4_pcol;
      s5_x0    <= s4_x0;
      s5_x1    <= s4_x1;
      s5_a     <= s4_a;
      s5_b     <= s4_b;
      s5_selx  <= s4_selx;
      s5_sely  <= s4_sely;
      s5_base0 <= s4_base0;
      s5_base1 <= s4_base1;
    end
  end

  // Address, weight and tag for the current access
  logic [ROWP_W-1:0]         rd_row;
  logic [CRD_W-1:0]          rd_col;
  logic [SUM_W-1:0]          rd_sum;
  logic [LADDR_W-1:0]        ld_addr;
  logic [ADDR_W-1:0]         mem_addr;
  logic                      mem_we, mem_re;
  logic [WEIGHT_BITS:0]      wx, wy;
  logic [WGT_W-1:0]          wgt_next;
  tsp_pkg::blend_tag_t       tag_next;

  always_comb begin
    rd_row   = s5_phase[1] ? s5_base1 : s5_base0;
    rd_col   = !s5_bil ? s5_pcol : (s5_phase[0] ? s5_x1 : s5_x0);
    rd_sum   = SUM_W'(rd_row) + SUM_W'(rd_col);
    ld_addr  = LADDR_W'(s5_index);
    mem_addr = s5_load ? ld_addr[ADDR_W-1:0] : rd_sum[ADDR_W-1:0];
    mem_we   = s5_valid && s5_load;
    mem_re   = s5_valid && !s5_load;
    wx       = s5_phase[0] ? {1'b0, s5_a} : ONE - {1'b0, s5_a};
    wy       = s5_phase[1] ? {1'b0, s5_b} : ONE - {1'b0, s5_b};
    wgt_next = s5_bil ? WGT_W'(wx) * WGT_W'(wy) : ONE_SQ;
    tag_next.valid     = mem_re;
    tag_next.first     = !s5_bil || s5_phase == 2'd0;
    tag_next.last      = !s5_bil || s5_phase == 2'd3;
    tag_next.alpha_hit = !s5_bil || s5_phase == {s5_sely, s5_selx};
  end

  // Texel memory, single port, registered read data
  logic [tsp_pkg::WORD_W-1:0] texel_mem [TEXEL_DEPTH];
  logic [tsp_pkg::WORD_W-1:0] rdata;
  tsp_pkg::blend_tag_t        tag;
  logic [WGT_W-1:0]           wgt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      texel_mem[mem_addr] <= s5_word;
    end else if (mem_re) begin
      rdata <= texel_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= tag_next;
    end
    wgt <= wgt_next;
  end

  tsp_blend #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .tag         (tag),
    .wgt         (wgt),
    .rdata       (rdata),
    .result_valid(result_valid),
    .result      (result)
  );

  // Checks
  `ASSERT_IMPLIES(a_phase_only_bilinear, s5_phase != 2'd0, s5_valid && s5_bil && !s5_load, "sequencer phase moved outside a bilinear sample")
  `ASSERT_NEXT(a_phase_steps, s5_valid && s5_bil && !s5_load && s5_phase != 2'd3, s5_valid && s5_phase == $past(s5_phase) + 2'd1, "bilinear reads did not advance in order")
  `ASSERT_NEXT(a_write_no_tag, mem_we, !tag.valid, "texel load produced a blend request")

endmodule
